@@ rtl/core/uart_with_interrupt_controller_defines.svh @@
// Assertion macros for the UART and interrupt controller block.
// Included by the RTL files that carry assertions; no other dependencies.
// Macro bodies are empty when SYNTHESIS is defined.
`ifndef UART_WITH_INTERRUPT_CONTROLLER_DEFINES_SVH
`define UART_WITH_INTERRUPT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define UWIC_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("uart_with_interrupt_controller: assertion failed");
`define UWIC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("uart_with_interrupt_controller: implication failed");
`else
`define UWIC_ASSERT(label, clk_sig, rst_sig, prop)
`define UWIC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons)
`endif

`endif

@@ rtl/core/uwic_pkg.sv @@
// Shared types and constants for the UART and interrupt controller block.
// No dependencies; imported by every module of the block.
package uwic_pkg;

  // Device sizing
  localparam int MAX_HARTS     = 4;
  localparam int CTX_SLOTS     = 2 * MAX_HARTS;
  localparam int CTX_W         = $clog2(CTX_SLOTS);
  localparam int HART_CNT_W    = 3;
  localparam int RX_FIFO_DEPTH = 16;
  localparam int RX_PTR_W      = $clog2(RX_FIFO_DEPTH);
  localparam int RX_FILL_W     = $clog2(RX_FIFO_DEPTH + 1);
  localparam int UART_SPAN     = 256;
  localparam int PLIC_SPAN     = 67108864;
  localparam int UART_RF_DEPTH = 8;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int OFF_W   = 26;
  localparam int LEN_W   = 3;
  localparam int DATA_W  = 32;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 56;
  localparam int ID_W    = 5;

  // PLIC map
  localparam int UART_SRC   = 10;
  localparam int PEND_OFF   = 'h1000;
  localparam int EN_BASE    = 'h2000;
  localparam int EN_STRIDE  = 'h80;
  localparam int EN_SH      = $clog2(EN_STRIDE);
  localparam int CTX_BASE   = 'h200000;
  localparam int CTX_STRIDE = 'h1000;
  localparam int CTX_SH     = $clog2(CTX_STRIDE);
  localparam int CTX_CLAIM  = 'h4;

  // UART register indexes
  localparam logic [2:0] UART_RBR = 3'd0;
  localparam logic [2:0] UART_IER = 3'd1;
  localparam logic [2:0] UART_IIR = 3'd2;
  localparam logic [2:0] UART_LSR = 3'd5;
  localparam logic [2:0] UART_MSR = 3'd6;

  // UART register bits and codes
  localparam int         IER_RX_BIT = 0;
  localparam int         IER_TX_BIT = 1;
  localparam int         FCR_CLR_BIT = 1;
  localparam logic [7:0] IIR_RX     = 8'h04;
  localparam logic [7:0] IIR_TX     = 8'h02;
  localparam logic [7:0] IIR_NONE   = 8'h01;
  localparam logic [7:0] LSR_BASE   = 8'h60;

  localparam logic [LEN_W-1:0] LEN_BYTE = 3'd1;
  localparam logic [LEN_W-1:0] LEN_WORD = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_UART_RD = 3'd0,
    CMD_UART_WR = 3'd1,
    CMD_PLIC_RD = 3'd2,
    CMD_PLIC_WR = 3'd3,
    CMD_RX_BYTE = 3'd4
  } cmd_t;

  // Qualified operation for one transaction, driven by the top level
  typedef struct packed {
    logic              uart_rd;
    logic              uart_wr;
    logic              rx_arrive;
    logic              plic_rd;
    logic              plic_wr;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] wdata;
  } req_t;

  // UART response and interrupt status
  typedef struct packed {
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       push_ok;
    logic       sync;
    logic       irq;
  } uart_resp_t;

endpackage

@@ rtl/core/uwic_uart.sv @@
// 16550-style UART core: register file, RX FIFO and transmit interrupt flag.
// Depends on uwic_pkg and uart_with_interrupt_controller_defines.svh.
`include "uart_with_interrupt_controller_defines.svh"

module uwic_uart import uwic_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  output uart_resp_t resp
);

  logic [7:0]           rf [UART_RF_DEPTH];
  logic [7:0]           rx_store [RX_FIFO_DEPTH];
  logic [RX_PTR_W-1:0]  rx_rd_ptr, rx_rd_ptr_next;
  logic [RX_PTR_W-1:0]  rx_wr_ptr, rx_wr_ptr_next;
  logic [RX_FILL_W-1:0] rx_fill, rx_fill_next;
  logic                 tx_flag, tx_flag_next;
  logic [2:0]           idx;
  logic [7:0]           ch;
  logic                 rf_we;
  logic                 store_we;
  logic                 fifo_clr;
  logic                 rx_irq, tx_irq;
  logic [7:0]           ier_next;

  function automatic logic [RX_PTR_W-1:0] ptr_inc(input logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign idx    = req.offset[2:0];
  assign ch     = req.wdata[7:0];
  assign rx_irq = (rx_fill != '0) && rf[UART_IER][IER_RX_BIT];
  assign tx_irq = tx_flag && rf[UART_IER][IER_TX_BIT];

  always_comb begin
    rx_rd_ptr_next = rx_rd_ptr;
    rx_wr_ptr_next = rx_wr_ptr;
    rx_fill_next   = rx_fill;
    tx_flag_next   = tx_flag;
    rf_we          = 1'b0;
    store_we       = 1'b0;
    fifo_clr       = 1'b0;
    ier_next       = rf[UART_IER];
    resp           = '0;
    if (req.uart_rd) begin
      unique case (idx)
        UART_RBR: begin
          if (rx_fill != '0) begin
            resp.rdata     = rx_store[rx_rd_ptr];
            rx_rd_ptr_next = ptr_inc(rx_rd_ptr);
            rx_fill_next   = rx_fill - 1'b1;
            resp.sync      = 1'b1;
          end
        end
        UART_IIR: resp.rdata = rx_irq ? IIR_RX : (tx_irq ? IIR_TX : IIR_NONE);
        UART_LSR: resp.rdata = LSR_BASE | {7'd0, rx_fill != '0};
        UART_MSR: resp.rdata = '0;
        default:  resp.rdata = rf[idx];
      endcase
    end else if (req.uart_wr) begin
      unique case (idx)
        UART_RBR: begin
          resp.tx_valid = 1'b1;
          resp.tx_byte  = ch;
          if (rf[UART_IER][IER_TX_BIT]) begin
            tx_flag_next = 1'b1;
            resp.sync    = 1'b1;
          end
        end
        UART_IER: begin
          rf_we        = 1'b1;
          ier_next     = ch;
          tx_flag_next = ch[IER_TX_BIT];
          resp.sync    = 1'b1;
        end
        UART_IIR: begin
          // FCR write; bit 1 flushes the receive FIFO
          rf_we     = 1'b1;
          resp.sync = 1'b1;
          if (ch[FCR_CLR_BIT]) begin
            fifo_clr       = 1'b1;
            rx_rd_ptr_next = '0;
            rx_wr_ptr_next = '0;
            rx_fill_next   = '0;
          end
        end
        default: rf_we = 1'b1;
      endcase
    end else if (req.rx_arrive) begin
      if (rx_fill < RX_FILL_W'(RX_FIFO_DEPTH)) begin
        store_we       = 1'b1;
        rx_wr_ptr_next = ptr_inc(rx_wr_ptr);
        rx_fill_next   = rx_fill + 1'b1;
        resp.sync      = 1'b1;
        resp.push_ok   = 1'b1;
      end
    end
    resp.irq = ((rx_fill_next != '0) && ier_next[IER_RX_BIT]) ||
               (tx_flag_next && ier_next[IER_TX_BIT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_rd_ptr <= '0;
      rx_wr_ptr <= '0;
      rx_fill   <= '0;
      tx_flag   <= 1'b0;
      for (int i = 0; i < UART_RF_DEPTH; i++) begin
        rf[i] <= '0;
      end
    end else begin
      rx_rd_ptr <= rx_rd_ptr_next;
      rx_wr_ptr <= rx_wr_ptr_next;
      rx_fill   <= rx_fill_next;
      tx_flag   <= tx_flag_next;
      if (rf_we) begin
        rf[idx] <= ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      rx_store[rx_wr_ptr] <= ch;
    end
  end

  `UWIC_ASSERT(a_fill_bound, clk, rst, rx_fill <= RX_FILL_W'(RX_FIFO_DEPTH))
  `UWIC_ASSERT_IMPL(a_empty_ptrs, clk, rst, rx_fill == '0, rx_rd_ptr == rx_wr_ptr)
  `UWIC_ASSERT(a_flush, clk, rst, fifo_clr |=> (rx_fill == '0))

endmodule

@@ rtl/core/uwic_plic.sv @@
// PLIC-style interrupt controller: pending word, per-context enables and claims.
// Depends on uwic_pkg; takes the UART interrupt status from uwic_uart.
module uwic_plic import uwic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic [HART_CNT_W-1:0] num_harts,
  input  uart_resp_t            uart,
  output logic [DATA_W-1:0]     rdata,
  output logic [MAX_HARTS-1:0]  meip_next,
  output logic [MAX_HARTS-1:0]  seip_next
);

  logic [DATA_W-1:0] pending, pending_next;
  logic [DATA_W-1:0] en [CTX_SLOTS];
  logic [DATA_W-1:0] en_next [CTX_SLOTS];
  logic [ID_W-1:0]   claim [CTX_SLOTS];
  logic [HART_CNT_W:0] ctx_count;
  logic [OFF_W-1:0]  en_rel, cl_rel;
  logic              pend_hit, en_hit, en_word, cl_hit, cl_word;
  logic [CTX_W-1:0]  sel_ctx;
  logic [DATA_W-1:0] en_sel;
  logic [ID_W-1:0]   claim_sel;
  logic [ID_W-1:0]   low_id;
  logic              en_we, claim_we, plic_sync;
  logic [ID_W-1:0]   claim_wd;

  // Lowest set bit among sources 1 to 31; 0 when none
  function automatic logic [ID_W-1:0] lowest_active(input logic [DATA_W-1:0] a);
    logic [ID_W-1:0] id;
    id = '0;
    for (int i = DATA_W - 1; i >= 1; i--) begin
      if (a[i]) begin
        id = ID_W'(i);
      end
    end
    return id;
  endfunction

  assign ctx_count = (num_harts <= HART_CNT_W'(MAX_HARTS)) ? {num_harts, 1'b0} : '0;

  assign en_rel   = req.offset - OFF_W'(EN_BASE);
  assign cl_rel   = req.offset - OFF_W'(CTX_BASE);
  assign pend_hit = req.offset == OFF_W'(PEND_OFF);
  assign en_hit   = (req.offset >= OFF_W'(EN_BASE)) &&
                    (en_rel < OFF_W'(ctx_count) * OFF_W'(EN_STRIDE));
  assign en_word  = en_rel[EN_SH-1:0] == '0;
  assign cl_hit   = (req.offset >= OFF_W'(CTX_BASE)) &&
                    (cl_rel < OFF_W'(ctx_count) * OFF_W'(CTX_STRIDE));
  assign cl_word  = cl_rel[CTX_SH-1:0] == CTX_SH'(CTX_CLAIM);

  assign sel_ctx   = en_hit ? en_rel[EN_SH +: CTX_W] : cl_rel[CTX_SH +: CTX_W];
  assign en_sel    = en[sel_ctx];
  assign claim_sel = claim[sel_ctx];
  assign low_id    = lowest_active(pending & en_sel);

  always_comb begin
    pending_next = pending;
    rdata        = '0;
    en_we        = 1'b0;
    claim_we     = 1'b0;
    claim_wd     = '0;
    plic_sync    = 1'b0;
    if (req.plic_rd) begin
      priority if (pend_hit) begin
        rdata = pending;
      end else if (en_hit) begin
        if (en_word) begin
          rdata = en_sel;
        end
      end else if (cl_hit && cl_word) begin
        if (claim_sel == '0 && low_id != '0) begin
          claim_we             = 1'b1;
          claim_wd             = low_id;
          pending_next[low_id] = 1'b0;
          rdata                = DATA_W'(low_id);
        end else begin
          rdata = DATA_W'(claim_sel);
        end
      end
    end else if (req.plic_wr) begin
      priority if (pend_hit) begin
        pending_next = req.wdata;
        plic_sync    = 1'b1;
      end else if (en_hit) begin
        en_we = en_word;
      end else if (cl_hit && cl_word && req.wdata == DATA_W'(claim_sel)) begin
        // claim completion
        claim_we  = 1'b1;
        plic_sync = 1'b1;
      end
    end
    if (plic_sync || uart.sync) begin
      pending_next[UART_SRC] = uart.irq;
    end
  end

  always_comb begin
    for (int c = 0; c < CTX_SLOTS; c++) begin
      en_next[c] = en[c];
    end
    if (en_we) begin
      en_next[sel_ctx] = req.wdata;
    end
  end

  always_comb begin
    for (int h = 0; h < MAX_HARTS; h++) begin
      meip_next[h] = (HART_CNT_W'(h) < num_harts) &&
                     (num_harts <= HART_CNT_W'(MAX_HARTS)) &&
                     ((pending_next & en_next[2 * h]) != '0);
      seip_next[h] = (HART_CNT_W'(h) < num_harts) &&
                     (num_harts <= HART_CNT_W'(MAX_HARTS)) &&
                     ((pending_next & en_next[2 * h + 1]) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int c = 0; c < CTX_SLOTS; c++) begin
        en[c]    <= '0;
        claim[c] <= '0;
      end
    end else begin
      pending <= pending_next;
      for (int c = 0; c < CTX_SLOTS; c++) begin
        en[c] <= en_next[c];
      end
      if (claim_we) begin
        claim[sel_ctx] <= claim_wd;
      end
    end
  end

endmodule

@@ rtl/core/uart_with_interrupt_controller.sv @@
// Top level: 16550-style UART wired to source 10 of a PLIC-style controller.
// Depends on uwic_pkg, uwic_uart and uwic_plic.
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one bus access or one received byte per transaction
//  m_axis    | out       | one result per input transaction
//  cfg       | in        | hart count register write
//
// Flow: one transaction per cycle while m_axis_tready stays high. An accepted
// input is held in the input register, then decoded and applied, and its
// result is captured in the result register, from which it can be taken.
// The UART and PLIC state change at the edge the result is registered, so the
// next transaction sees it.
// Reset: synchronous, clears all control state; the hart count returns to 1.
// Stalls: m_axis_tready low holds the result register; the input register
// can still take one transaction while empty, then s_axis_tready drops.
module uart_with_interrupt_controller import uwic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: hart count
  input  logic                  cfg_we,
  input  logic [HART_CNT_W-1:0] cfg_wdata,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] cmd, [28:3] offset, [31:29] access_bytes, [63:32] wdata
  input  logic [IN_W-1:0]       s_axis_tdata,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] ok, [32:1] rdata, [33] tx_valid, [41:34] tx_byte,
  // [45:42] meip_lines, [49:46] seip_lines, [55:50] zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic [HART_CNT_W-1:0] num_harts;

  // Input register
  logic            in_valid;
  logic [IN_W-1:0] in_data;
  logic            proc_fire;

  // Result register
  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic [OUT_W-1:0] out_data_next;

  // Decoded fields
  cmd_t              cmd;
  logic [OFF_W-1:0]  offset;
  logic [LEN_W-1:0]  access_bytes;
  logic [DATA_W-1:0] wdata;
  logic              uart_ok, plic_ok;
  logic              ok;
  logic [DATA_W-1:0] rdata;

  req_t                 req;
  uart_resp_t           uart_resp;
  logic [DATA_W-1:0]    plic_rdata;
  logic [MAX_HARTS-1:0] meip_next, seip_next;

  // A held transaction moves on when the result register is free or draining
  assign proc_fire     = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_harts <= HART_CNT_W'(1);
    end else if (cfg_we) begin
      num_harts <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (proc_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
    if (proc_fire) begin
      out_data <= out_data_next;
    end
  end

  // Field unpacking
  assign cmd          = cmd_t'(in_data[CMD_W-1:0]);
  assign offset       = in_data[CMD_W +: OFF_W];
  assign access_bytes = in_data[CMD_W + OFF_W +: LEN_W];
  assign wdata        = in_data[CMD_W + OFF_W + LEN_W +: DATA_W];

  // Window and length checks; a rejected access has no effect
  assign uart_ok = (offset < OFF_W'(UART_SPAN)) &&
                   (access_bytes == LEN_BYTE || access_bytes == LEN_WORD);
  assign plic_ok = ({1'b0, offset} < (OFF_W + 1)'(PLIC_SPAN)) && (access_bytes == LEN_WORD);

  always_comb begin
    req        = '0;
    req.offset = offset;
    req.wdata  = wdata;
    if (proc_fire) begin
      unique case (cmd)
        CMD_UART_RD: req.uart_rd   = uart_ok;
        CMD_UART_WR: req.uart_wr   = uart_ok;
        CMD_PLIC_RD: req.plic_rd   = plic_ok;
        CMD_PLIC_WR: req.plic_wr   = plic_ok;
        CMD_RX_BYTE: req.rx_arrive = 1'b1;
        default: ;
      endcase
    end
  end

  uwic_uart u_uart (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (uart_resp)
  );

  uwic_plic u_plic (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .num_harts  (num_harts),
    .uart       (uart_resp),
    .rdata      (plic_rdata),
    .meip_next  (meip_next),
    .seip_next  (seip_next)
  );

  // Result assembly
  assign ok = req.uart_rd || req.uart_wr || req.plic_rd || req.plic_wr ||
              uart_resp.push_ok;

  always_comb begin
    rdata = '0;
    if (req.uart_rd) begin
      rdata = DATA_W'(uart_resp.rdata);
    end else if (req.plic_rd) begin
      rdata = plic_rdata;
    end
  end

  assign out_data_next = {6'd0, seip_next, meip_next, uart_resp.tx_byte,
                          uart_resp.tx_valid, rdata, ok};

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for uart_with_interrupt_controller: a directed table of register
// accesses, then random UART/PLIC traffic over several hart counts, checked by an in-bench model.
// Depends on uwic_pkg and the block's RTL only.
module tb;
  import uwic_pkg::*;

  // Reserved command codes, which the block must refuse
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam int STALL_LIMIT = 1000;   // cycles with no transaction on either side
  localparam int PHASE_ITEMS = 175;    // random transactions per hart-count setting
  localparam int DRAIN_WAIT  = 6;      // idle wait after draining, before a hart count write or the end

  // Hart counts visited after the directed part: extremes, out of range, and the usual ones
  localparam int unsigned HARTS_PLAN [7] = '{4, 0, 7, 2, 3, 1, 4};
  localparam int CALM_PHASE = 3;       // this phase runs with no idling on either side

  // Fields of one input transaction, lowest bits last
  typedef struct packed {
    logic [DATA_W-1:0] wdata;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  offset;
    logic [CMD_W-1:0]  cmd;
  } bus_access_t;

  // Fields of one result transaction, lowest bits last
  typedef struct packed {
    logic [MAX_HARTS-1:0] seip;
    logic [MAX_HARTS-1:0] meip;
    logic [7:0]           tx_byte;
    logic                 tx_valid;
    logic [DATA_W-1:0]    rdata;
    logic                 ok;
  } bus_reply_t;

  localparam int REPLY_W = $bits(bus_reply_t);

  typedef struct {
    bus_access_t acc;
    bit          typed;   // want holds a hand-written result
    bus_reply_t  want;
  } plan_row_t;

  typedef enum logic [1:0] {PLIC_NONE, PLIC_PEND, PLIC_EN, PLIC_CLAIM} plic_reg_t;

  // DUT connections; every input has a known value from time zero
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [HART_CNT_W-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  // Model state: UART registers and RX FIFO, PLIC pending, enables and claims
  logic [HART_CNT_W-1:0] harts;
  logic [7:0]            uart_rf   [UART_RF_DEPTH];
  logic [7:0]            rx_mem    [RX_FIFO_DEPTH];
  logic [RX_PTR_W-1:0]   rx_rd, rx_wr;
  logic [RX_FILL_W-1:0]  rx_fill;
  logic                  tx_flag;
  logic [31:0]           pend;
  logic [31:0]           en_word   [CTX_SLOTS];
  logic [ID_W-1:0]       claimed   [CTX_SLOTS];

  bus_reply_t  replies_due [$];   // expected results, oldest first
  plan_row_t   directed [$];
  int unsigned mismatches = 0;
  int unsigned quiet      = 0;
  bit          calm       = 1'b0;
  bus_reply_t  want, got;

  always #5 clk = ~clk;

  uart_with_interrupt_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic void clear_model();
    harts   = 1;
    rx_rd   = '0;
    rx_wr   = '0;
    rx_fill = '0;
    tx_flag = 1'b0;
    pend    = '0;
    foreach (uart_rf[i]) uart_rf[i] = '0;
    foreach (rx_mem[i]) rx_mem[i] = '0;
    foreach (en_word[i]) en_word[i] = '0;
    foreach (claimed[i]) claimed[i] = '0;
  endfunction

  function automatic bit rx_irq_on();
    return rx_fill != 0 && uart_rf[UART_IER][IER_RX_BIT];
  endfunction

  function automatic bit tx_irq_on();
    return tx_flag && uart_rf[UART_IER][IER_TX_BIT];
  endfunction

  // UART interrupt is only copied into pending bit 10 at these points
  function automatic void resync_uart();
    pend[UART_SRC] = rx_irq_on() || tx_irq_on();
  endfunction

  // Two contexts per hart; an out-of-range hart count gives none
  function automatic int unsigned live_contexts();
    return (harts <= MAX_HARTS) ? 2 * harts : 0;
  endfunction

  function automatic logic [ID_W-1:0] lowest_source(input logic [31:0] active);
    for (int i = 1; i < 32; i++)
      if (active[i]) return ID_W'(i);
    return '0;
  endfunction

  function automatic plic_reg_t plic_decode(input int unsigned off, output int unsigned ctx);
    int unsigned cc;
    cc  = live_contexts();
    ctx = 0;
    if (off == PEND_OFF) return PLIC_PEND;
    if (off >= EN_BASE && off < EN_BASE + cc * EN_STRIDE) begin
      ctx = (off - EN_BASE) >> EN_SH;
      return ((off - EN_BASE) % EN_STRIDE == 0) ? PLIC_EN : PLIC_NONE;
    end
    if (off >= CTX_BASE && off < CTX_BASE + cc * CTX_STRIDE) begin
      ctx = (off - CTX_BASE) >> CTX_SH;
      return ((off - CTX_BASE) % CTX_STRIDE == CTX_CLAIM) ? PLIC_CLAIM : PLIC_NONE;
    end
    return PLIC_NONE;
  endfunction

  // Applies one accepted transaction to the model and returns its result
  function automatic bus_reply_t apply_access(input bus_access_t a);
    bus_reply_t      rep;
    logic [2:0]      idx;
    logic [7:0]      ch;
    int unsigned     ctx, cc, h;
    logic [ID_W-1:0] id;
    plic_reg_t       kind;
    rep = '0;
    idx = a.offset[2:0];
    ch  = a.wdata[7:0];
    case (a.cmd)
      CMD_UART_RD, CMD_UART_WR: begin
        if (a.offset < UART_SPAN && (a.len == LEN_BYTE || a.len == LEN_WORD)) begin
          rep.ok = 1'b1;
          if (a.cmd == CMD_UART_RD) begin
            case (idx)
              UART_RBR: if (rx_fill != 0) begin
                rep.rdata = rx_mem[rx_rd];
                rx_rd++;
                rx_fill--;
                resync_uart();
              end
              UART_IIR: rep.rdata = rx_irq_on() ? IIR_RX : (tx_irq_on() ? IIR_TX : IIR_NONE);
              UART_LSR: rep.rdata = LSR_BASE | (rx_fill != 0);
              UART_MSR: rep.rdata = '0;
              default:  rep.rdata = uart_rf[idx];
            endcase
          end else begin
            case (idx)
              UART_RBR: begin
                rep.tx_valid = 1'b1;
                rep.tx_byte  = ch;
                if (uart_rf[UART_IER][IER_TX_BIT]) begin
                  tx_flag = 1'b1;
                  resync_uart();
                end
              end
              UART_IER: begin
                uart_rf[UART_IER] = ch;
                tx_flag = ch[IER_TX_BIT];
                resync_uart();
              end
              UART_IIR: begin
                uart_rf[UART_IIR] = ch;
                if (ch[FCR_CLR_BIT]) begin
                  rx_rd   = '0;
                  rx_wr   = '0;
                  rx_fill = '0;
                end
                resync_uart();
              end
              default: uart_rf[idx] = ch;
            endcase
          end
        end
      end
      CMD_PLIC_RD, CMD_PLIC_WR: begin
        if (a.offset < PLIC_SPAN && a.len == LEN_WORD) begin
          rep.ok = 1'b1;
          kind   = plic_decode(a.offset, ctx);
          if (a.cmd == CMD_PLIC_RD) begin
            case (kind)
              PLIC_PEND: rep.rdata = pend;
              PLIC_EN:   rep.rdata = en_word[ctx];
              PLIC_CLAIM: begin
                // a claim takes the lowest enabled pending source and clears it
                if (claimed[ctx] == 0) begin
                  id = lowest_source(pend & en_word[ctx]);
                  if (id != 0) begin
                    claimed[ctx] = id;
                    pend[id]     = 1'b0;
                  end
                end
                rep.rdata = claimed[ctx];
              end
              default: rep.rdata = '0;
            endcase
          end else begin
            case (kind)
              PLIC_PEND: begin
                pend = a.wdata;
                resync_uart();
              end
              PLIC_EN: en_word[ctx] = a.wdata;
              PLIC_CLAIM: if (a.wdata == claimed[ctx]) begin
                claimed[ctx] = '0;
                resync_uart();
              end
              default: ;
            endcase
          end
        end
      end
      CMD_RX_BYTE: if (rx_fill < RX_FIFO_DEPTH) begin
        rx_mem[rx_wr] = ch;
        rx_wr++;
        rx_fill++;
        resync_uart();
        rep.ok = 1'b1;
      end
      default: ;
    endcase
    cc = live_contexts();
    for (h = 0; h < MAX_HARTS; h++)
      if (2 * h + 1 < cc) begin
        rep.meip[h] = |(pend & en_word[2 * h]);
        rep.seip[h] = |(pend & en_word[2 * h + 1]);
      end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic bus_access_t make_access(input logic [CMD_W-1:0] cmd,
                                              input int unsigned off,
                                              input logic [LEN_W-1:0] len,
                                              input logic [DATA_W-1:0] data);
    bus_access_t a;
    a.cmd    = cmd;
    a.offset = off[OFF_W-1:0];
    a.len    = len;
    a.wdata  = data;
    return a;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input int unsigned off,
                         input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data,
                         input bit typed, input logic ok, input logic [DATA_W-1:0] rdata);
    plan_row_t r;
    r.acc        = make_access(cmd, off, len, data);
    r.typed      = typed;
    r.want       = '0;
    r.want.ok    = ok;
    r.want.rdata = rdata;
    directed.push_back(r);
  endtask

  // Mostly meaningful register addresses, with some misaligned, out-of-window and junk ones
  function automatic bus_access_t pick_access();
    int unsigned       sel, p, ctx, off;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    sel  = $urandom_range(99);
    data = $urandom();
    ctx  = $urandom_range(CTX_SLOTS);   // one past the last slot on purpose
    if (sel < 3)
      return make_access($urandom_range(CMD_RSVD7, CMD_RSVD5), $urandom(),
                         $urandom_range(7), data);
    if (sel < 22)
      return make_access(CMD_RX_BYTE, $urandom(), $urandom_range(7), data);
    if (sel < 62) begin
      cmd = (sel < 45) ? CMD_UART_RD : CMD_UART_WR;
      p   = $urandom_range(99);
      off = (p < 80) ? $urandom_range(7) :
            (p < 95) ? $urandom_range(UART_SPAN - 1) : $urandom();
      len = ($urandom_range(9) == 0) ? $urandom_range(7) :
            ($urandom_range(1) ? LEN_BYTE : LEN_WORD);
      // keep FIFO clears rare enough for the FIFO to fill up now and then
      if (cmd == CMD_UART_WR && off[2:0] == UART_IIR && $urandom_range(3) != 0)
        data[FCR_CLR_BIT] = 1'b0;
      return make_access(cmd, off, len, data);
    end
    cmd = (sel < 80) ? CMD_PLIC_RD : CMD_PLIC_WR;
    len = ($urandom_range(9) == 0) ? $urandom_range(7) : LEN_WORD;
    p   = $urandom_range(99);
    if (p < 20) begin
      off  = PEND_OFF;
      data = data & $urandom();
    end else if (p < 45) begin
      off = EN_BASE + ctx * EN_STRIDE;
      if ($urandom_range(7) == 0)
        off += $urandom_range(EN_STRIDE - 1, 1);
      else
        data[UART_SRC] = $urandom_range(1);
    end else if (p < 85) begin
      off = CTX_BASE + ctx * CTX_STRIDE +
            (($urandom_range(7) == 0) ? $urandom_range(CTX_STRIDE - 1) : CTX_CLAIM);
      // completions mostly hand back the id that was claimed
      if (ctx < CTX_SLOTS && $urandom_range(4) != 0) data = claimed[ctx];
    end else begin
      off = $urandom();
    end
    return make_access(cmd, off, len, data);
  endfunction

  // Presents one transaction, idling first now and then; the model runs once it is taken
  task automatic issue(input bus_access_t acc, input bit typed, input bus_reply_t typed_rep);
    bus_reply_t rep;
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= acc;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rep = apply_access(acc);
    replies_due.push_back(typed ? typed_rep : rep);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // The hart count is only written with the block idle
  task automatic set_harts(input int unsigned v);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[HART_CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    harts      = v[HART_CNT_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Result check: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic cmp(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h, got %h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        got  = m_axis_tdata[REPLY_W-1:0];
        cmp("ok", want.ok, got.ok);
        cmp("rdata", want.rdata, got.rdata);
        cmp("tx_valid", want.tx_valid, got.tx_valid);
        cmp("tx_byte", want.tx_byte, got.tx_byte);
        cmp("meip_lines", want.meip, got.meip);
        cmp("seip_lines", want.seip, got.seip);
        cmp("padding", '0, m_axis_tdata[OUT_W-1:REPLY_W]);
      end
    end
    // receiver stalls at random with a chance of 7 in 100, never in the calm phase
    m_axis_tready <= !rst && !(!calm && $urandom_range(99) < 7);
  end

  // Watchdog: too long without a transaction on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n, burst;
    bit          held;
    bus_reply_t  blank;
    blank = '0;
    clear_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values and refusals are typed in, the rest follow the model.
    // All typed rows come first, while no interrupt line can be high.
    add_row(CMD_UART_RD, UART_LSR, LEN_BYTE, '0, 1, 1'b1, LSR_BASE);
    add_row(CMD_UART_RD, UART_IIR, LEN_WORD, '0, 1, 1'b1, IIR_NONE);
    add_row(CMD_UART_RD, UART_RBR, LEN_BYTE, '0, 1, 1'b1, '0);   // empty FIFO reads zero
    add_row(CMD_UART_RD, UART_MSR, LEN_BYTE, '0, 1, 1'b1, '0);
    add_row(CMD_UART_RD, UART_SPAN - 1, LEN_BYTE, '0, 1, 1'b1, '0);
    add_row(CMD_UART_WR, UART_RBR, 3'd2, 32'h55, 1, 1'b0, '0);   // bad length, no byte out
    add_row(CMD_UART_RD, UART_SPAN, LEN_BYTE, '0, 1, 1'b0, '0);  // outside the window
    add_row(CMD_PLIC_RD, PEND_OFF, LEN_BYTE, '0, 1, 1'b0, '0);   // PLIC takes words only
    add_row(CMD_PLIC_RD, PEND_OFF, LEN_WORD, '0, 1, 1'b1, '0);
    add_row(CMD_RSVD5, '0, LEN_WORD, '0, 1, 1'b0, '0);
    add_row(CMD_RSVD7, 32'h3FF_FFFF, 3'd7, 32'hFFFF_FFFF, 1, 1'b0, '0);
    // interrupt path: enable all sources on context 0, raise UART rx and tx
    add_row(CMD_PLIC_WR, EN_BASE, LEN_WORD, 32'hFFFF_FFFF, 0, 1'b0, '0);
    add_row(CMD_UART_WR, UART_IER, LEN_BYTE, 32'h03, 0, 1'b0, '0);
    add_row(CMD_RX_BYTE, '0, '0, 32'hFF, 0, 1'b0, '0);
    add_row(CMD_RX_BYTE, 32'h3FF_FFFF, 3'd7, 32'hFFFF_FF00, 0, 1'b0, '0);
    add_row(CMD_UART_RD, UART_IIR, LEN_BYTE, '0, 0, 1'b0, '0);
    add_row(CMD_PLIC_RD, CTX_BASE + CTX_CLAIM, LEN_WORD, '0, 0, 1'b0, '0);
    add_row(CMD_PLIC_RD, CTX_BASE + CTX_CLAIM, LEN_WORD, '0, 0, 1'b0, '0);  // claim held
    add_row(CMD_PLIC_WR, CTX_BASE + CTX_CLAIM, LEN_WORD, 32'h3, 0, 1'b0, '0); // wrong id
    add_row(CMD_PLIC_WR, CTX_BASE + CTX_CLAIM, LEN_WORD, UART_SRC, 0, 1'b0, '0);
    add_row(CMD_UART_RD, UART_RBR, LEN_WORD, '0, 0, 1'b0, '0);
    add_row(CMD_UART_WR, UART_RBR, LEN_BYTE, 32'hFFFF_FFA5, 0, 1'b0, '0);   // byte out
    add_row(CMD_UART_WR, UART_IIR, LEN_BYTE, 32'h02, 0, 1'b0, '0);          // FIFO clear
    add_row(CMD_PLIC_WR, PEND_OFF, LEN_WORD, 32'hFFFF_FFFF, 0, 1'b0, '0);
    add_row(CMD_PLIC_RD, PEND_OFF, LEN_WORD, '0, 0, 1'b0, '0);
    add_row(CMD_PLIC_WR, 32'h3FF_FFFF, LEN_WORD, 32'h1234_5678, 0, 1'b0, '0); // unmapped
    add_row(CMD_PLIC_RD, EN_BASE + 2 * EN_STRIDE, LEN_WORD, '0, 0, 1'b0, '0); // no such ctx
    foreach (directed[i]) issue(directed[i].acc, directed[i].typed, directed[i].want);

    // Random traffic, one phase per hart count
    foreach (HARTS_PLAN[p]) begin
      set_harts(HARTS_PLAN[p]);
      calm = (p == CALM_PHASE);
      held = 1'b0;
      n    = 0;
      while (n < PHASE_ITEMS) begin
        // once per phase the sender holds off until every result is back
        if (!held && n >= PHASE_ITEMS / 2) begin
          drain();
          held = 1'b1;
        end
        if ($urandom_range(39) == 0) begin
          // a run of received bytes, long enough to overflow the FIFO now and then
          burst = $urandom_range(22, 16);
          repeat (burst)
            issue(make_access(CMD_RX_BYTE, $urandom(), $urandom_range(7), $urandom()), 0, blank);
          n += burst;
        end else begin
          issue(pick_access(), 0, blank);
          n++;
        end
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/uwic_pkg.sv
rtl/core/uwic_uart.sv
rtl/core/uwic_plic.sv
rtl/core/uart_with_interrupt_controller.sv
tb/sv/tb.sv
